FILE: hdl/i2cmrts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmrts_pkg: shared types for the I2C register transfer sequencer
// Bus command codes, sequencer phases, plan descriptors passed from the
// front end to the back end, and the expansion of a plan into result items.
// ----------------------------------------------------------------------------
package i2cmrts_pkg;

  // width of the remaining-byte counter
  localparam int CountBits = 8;
  localparam int WideBits  = (CountBits > 8) ? CountBits : 8;

  // plan queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [7:0] ReadBit = 8'h01;

  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [2:0] {
    CmdNone  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdSend  = 3'd3,
    CmdRecv  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KindReq  = 2'd0,
    KindData = 2'd1,
    KindAck  = 2'd2,
    KindRx   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OpProbe = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpRsvd  = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    PhIdle     = 7'b0000001,
    PhAddrAck  = 7'b0000010,
    PhRegAck   = 7'b0000100,
    PhWdata    = 7'b0001000,
    PhWdataAck = 7'b0010000,
    PhRaddrAck = 7'b0100000,
    PhRx       = 7'b1000000
  } phase_e;

  // what one accepted event turns into on the bus side
  typedef enum logic [2:0] {
    PlanStartAddr = 3'd0,  // start, send byte
    PlanSend      = 3'd1,  // send byte
    PlanFinish    = 3'd2,  // stop with done, flag is success
    PlanNeed      = 3'd3,  // ask host for next write byte
    PlanRestart   = 3'd4,  // stop, start, send byte
    PlanRecv      = 3'd5,  // receive, flag is NACK-after
    PlanRxLast    = 3'd6,  // stop with received byte and done
    PlanRxMore    = 3'd7   // receive next, carries received byte
  } plan_e;

  typedef struct packed {
    plan_e      plan;
    logic [7:0] data;
    logic       flag;
  } desc_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] send_byte;
    logic       send_nack;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done;
    logic       success;
    logic       need_data;
    logic       last;
  } res_t;

  function automatic logic [1:0] plan_len(plan_e p);
    logic [1:0] n;
    begin
      case (p)
        PlanStartAddr: n = 2'd2;
        PlanRestart:   n = 2'd3;
        default:       n = 2'd1;
      endcase
      return n;
    end
  endfunction

  // result item number 'step' of a plan; 'last' is set by the caller
  function automatic res_t expand(desc_t d, logic [1:0] step);
    res_t r;
    begin
      r = '0;
      case (d.plan)
        PlanStartAddr: begin
          r.cmd = (step == 2'd0) ? CmdStart : CmdSend;
          r.send_byte = (step == 2'd0) ? 8'h00 : d.data;
        end
        PlanSend: begin
          r.cmd = CmdSend;
          r.send_byte = d.data;
        end
        PlanFinish: begin
          r.cmd = CmdStop;
          r.done = 1'b1;
          r.success = d.flag;
        end
        PlanNeed: begin
          r.cmd = CmdNone;
          r.need_data = 1'b1;
        end
        PlanRestart: begin
          case (step)
            2'd0:    r.cmd = CmdStop;
            2'd1:    r.cmd = CmdStart;
            default: begin
              r.cmd = CmdSend;
              r.send_byte = d.data;
            end
          endcase
        end
        PlanRecv: begin
          r.cmd = CmdRecv;
          r.send_nack = d.flag;
        end
        PlanRxLast: begin
          r.cmd = CmdStop;
          r.read_data = d.data;
          r.read_valid = 1'b1;
          r.done = 1'b1;
          r.success = 1'b1;
        end
        PlanRxMore: begin
          r.cmd = CmdRecv;
          r.send_nack = d.flag;
          r.read_data = d.data;
          r.read_valid = 1'b1;
        end
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/i2cmrts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmrts_front: event classifier and transaction state
// Takes one event per cycle while accept_i is high, advances the transaction
// phase and pushes a back-end plan descriptor when the event yields items.
// ----------------------------------------------------------------------------
module i2cmrts_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           kind_i,
  input  wire logic [1:0]           operation_i,
  input  wire logic [7:0]           device_address_i,
  input  wire logic [7:0]           register_index_i,
  input  wire logic [7:0]           byte_count_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 nack_i,
  output logic                      push_o,
  output i2cmrts_pkg::desc_t        desc_o
);

  i2cmrts_pkg::phase_e phase_q, phase_d;
  logic [1:0]          op_q, op_d;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          reg_q, reg_d;
  i2cmrts_pkg::count_t bytes_q, bytes_d;

  logic                                  push_c;
  logic [i2cmrts_pkg::WideBits-1:0]      cnt_w;
  logic [i2cmrts_pkg::WideBits-1:0]      cnt_max;
  i2cmrts_pkg::count_t                   cnt_sat;
  i2cmrts_pkg::count_t                   rx_left;
  logic                                  op_ok;
  logic                                  ack_phase;

  assign cnt_w   = i2cmrts_pkg::WideBits'(byte_count_i);
  assign cnt_max = i2cmrts_pkg::WideBits'({i2cmrts_pkg::CountBits{1'b1}});
  assign cnt_sat = (cnt_w > cnt_max) ? i2cmrts_pkg::count_t'(cnt_max)
                                     : i2cmrts_pkg::count_t'(cnt_w);
  assign rx_left = (bytes_q == '0) ? '0 : bytes_q - i2cmrts_pkg::count_t'(1);

  assign op_ok = (operation_i == i2cmrts_pkg::OpProbe) ||
                 (operation_i == i2cmrts_pkg::OpWrite) ||
                 (operation_i == i2cmrts_pkg::OpRead);
  assign ack_phase = (phase_q == i2cmrts_pkg::PhAddrAck) ||
                     (phase_q == i2cmrts_pkg::PhRegAck) ||
                     (phase_q == i2cmrts_pkg::PhWdataAck) ||
                     (phase_q == i2cmrts_pkg::PhRaddrAck);

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    addr_d  = addr_q;
    reg_d   = reg_q;
    bytes_d = bytes_q;
    push_c  = 1'b0;
    desc_o  = '0;
    case (kind_i)
      i2cmrts_pkg::KindReq: begin
        if (phase_q == i2cmrts_pkg::PhIdle && op_ok) begin
          op_d    = operation_i;
          addr_d  = device_address_i;
          reg_d   = register_index_i;
          bytes_d = cnt_sat;
          if (operation_i == i2cmrts_pkg::OpRead && cnt_sat == '0) begin
            bytes_d = i2cmrts_pkg::count_t'(1);
          end
          push_c      = 1'b1;
          desc_o.plan = i2cmrts_pkg::PlanStartAddr;
          desc_o.data = device_address_i;
          phase_d     = i2cmrts_pkg::PhAddrAck;
        end
      end
      i2cmrts_pkg::KindData: begin
        if (phase_q == i2cmrts_pkg::PhWdata) begin
          push_c      = 1'b1;
          desc_o.plan = i2cmrts_pkg::PlanSend;
          desc_o.data = data_byte_i;
          bytes_d     = bytes_q - i2cmrts_pkg::count_t'(1);
          phase_d     = i2cmrts_pkg::PhWdataAck;
        end
      end
      i2cmrts_pkg::KindAck: begin
        if (ack_phase) begin
          push_c = 1'b1;
          if (nack_i) begin
            desc_o.plan = i2cmrts_pkg::PlanFinish;
            phase_d     = i2cmrts_pkg::PhIdle;
          end else begin
            case (phase_q)
              i2cmrts_pkg::PhAddrAck: begin
                if (op_q == i2cmrts_pkg::OpProbe) begin
                  desc_o.plan = i2cmrts_pkg::PlanFinish;
                  desc_o.flag = 1'b1;
                  phase_d     = i2cmrts_pkg::PhIdle;
                end else begin
                  desc_o.plan = i2cmrts_pkg::PlanSend;
                  desc_o.data = reg_q;
                  phase_d     = i2cmrts_pkg::PhRegAck;
                end
              end
              i2cmrts_pkg::PhRaddrAck: begin
                desc_o.plan = i2cmrts_pkg::PlanRecv;
                desc_o.flag = (bytes_q == '0) || (bytes_q == i2cmrts_pkg::count_t'(1));
                phase_d     = i2cmrts_pkg::PhRx;
              end
              default: begin
                // register index or write data acknowledged
                if (phase_q == i2cmrts_pkg::PhRegAck && op_q != i2cmrts_pkg::OpWrite) begin
                  desc_o.plan = i2cmrts_pkg::PlanRestart;
                  desc_o.data = addr_q | i2cmrts_pkg::ReadBit;
                  phase_d     = i2cmrts_pkg::PhRaddrAck;
                end else if (bytes_q == '0) begin
                  desc_o.plan = i2cmrts_pkg::PlanFinish;
                  desc_o.flag = 1'b1;
                  phase_d     = i2cmrts_pkg::PhIdle;
                end else begin
                  desc_o.plan = i2cmrts_pkg::PlanNeed;
                  phase_d     = i2cmrts_pkg::PhWdata;
                end
              end
            endcase
          end
        end
      end
      default: begin
        // received byte
        if (phase_q == i2cmrts_pkg::PhRx) begin
          push_c      = 1'b1;
          bytes_d     = rx_left;
          desc_o.data = data_byte_i;
          if (rx_left == '0) begin
            desc_o.plan = i2cmrts_pkg::PlanRxLast;
            phase_d     = i2cmrts_pkg::PhIdle;
          end else begin
            desc_o.plan = i2cmrts_pkg::PlanRxMore;
            desc_o.flag = (rx_left == i2cmrts_pkg::count_t'(1));
          end
        end
      end
    endcase
  end

  assign push_o = accept_i && push_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cmrts_pkg::PhIdle;
      op_q    <= '0;
      addr_q  <= '0;
      reg_q   <= '0;
      bytes_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      reg_q   <= reg_d;
      bytes_q <= bytes_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/i2cmrts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmrts_queue: plan descriptor queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module i2cmrts_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire i2cmrts_pkg::desc_t  push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     head_valid_o,
  output i2cmrts_pkg::desc_t       head_o
);

  i2cmrts_pkg::desc_t entries_q [i2cmrts_pkg::QueueDepth];
  logic [i2cmrts_pkg::QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [i2cmrts_pkg::QCntBits-1:0] count_q;
  logic do_push, do_pop;

  assign full_o       = (count_q == i2cmrts_pkg::QCntBits'(i2cmrts_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [i2cmrts_pkg::QPtrBits-1:0] next_ptr(
      logic [i2cmrts_pkg::QPtrBits-1:0] p);
    begin
      if (p == i2cmrts_pkg::QPtrBits'(i2cmrts_pkg::QueueDepth - 1)) begin
        return '0;
      end
      return p + i2cmrts_pkg::QPtrBits'(1);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + i2cmrts_pkg::QCntBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - i2cmrts_pkg::QCntBits'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/i2cmrts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmrts_back: plan expander and output register
// Walks the head plan into the output register one item per unstalled cycle.
// ----------------------------------------------------------------------------
module i2cmrts_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire i2cmrts_pkg::desc_t  head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output i2cmrts_pkg::res_t        res_o
);

  logic [1:0]        step_q;
  logic              out_valid_q;
  i2cmrts_pkg::res_t res_q;
  i2cmrts_pkg::res_t item;
  logic              is_last;
  logic              load;

  assign is_last = (step_q == i2cmrts_pkg::plan_len(head_i.plan) - 2'd1);
  always_comb begin
    item      = i2cmrts_pkg::expand(head_i, step_q);
    item.last = is_last;
  end

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= is_last ? 2'd0 : step_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: hdl/i2c_master_register_transfer_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_sequencer: register read/write sequencer
// Turns host requests and byte-engine responses into I2C bus commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries events: transaction
//   requests, write data bytes, ack responses and received bytes, all
//   coming back from the host or the byte-level engine. Output channel
//   (out_valid_o / out_stall_i) carries result items: bus commands plus
//   read data, need_data and done/success status; last_o marks the final
//   item caused by one event. Each event causes zero to three items.
//   After the transfer the plan is written to the queue, then expanded
//   into the output register, where the event's first item shows.
//   Events are taken one per cycle while the two-entry plan queue has
//   room; the output side issues one item per cycle while out_stall_i is
//   low, so the restart sequence's three items leave one after another.
//   Reset (rst_ni low, async) returns the phase to idle and empties the
//   queue and output register. A stall on the output holds the current
//   item; events keep being taken until the plan queue fills, then
//   in_stall_o rises. Ignored events (unexpected kind for the phase,
//   request while busy, reserved operation) are taken and produce nothing.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_sequencer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // events in
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] device_address_i,
  input  wire logic [7:0] register_index_i,
  input  wire logic [7:0] byte_count_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       nack_i,
  // result items out
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      bus_command_o,
  output logic [7:0]      send_byte_o,
  output logic            send_nack_after_o,
  output logic [7:0]      read_data_o,
  output logic            read_valid_o,
  output logic            done_res_o,
  output logic            success_o,
  output logic            need_data_o,
  output logic            last_o
);

  logic               accept;
  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  i2cmrts_pkg::desc_t push_desc;
  i2cmrts_pkg::desc_t head;
  i2cmrts_pkg::res_t  res;

  // an event is taken whenever the queue can hold its plan
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  i2cmrts_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .kind_i           (kind_i),
    .operation_i      (operation_i),
    .device_address_i (device_address_i),
    .register_index_i (register_index_i),
    .byte_count_i     (byte_count_i),
    .data_byte_i      (data_byte_i),
    .nack_i           (nack_i),
    .push_o           (push),
    .desc_o           (push_desc)
  );

  i2cmrts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back end drains plans to the output register, one item per unstalled cycle
  i2cmrts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign bus_command_o     = res.cmd;
  assign send_byte_o       = res.send_byte;
  assign send_nack_after_o = res.send_nack;
  assign read_data_o       = res.read_data;
  assign read_valid_o      = res.read_valid;
  assign done_res_o        = res.done;
  assign success_o         = res.success;
  assign need_data_o       = res.need_data;
  assign last_o            = res.last;

endmodule
`default_nettype wire

FILE: hdl/i2cmrts_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmrts_chk: port-level checks for the register transfer sequencer
// Watches the output channel for handshake and item-encoding slips.
// ----------------------------------------------------------------------------
module i2cmrts_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] bus_command_o,
  input wire logic       read_valid_o,
  input wire logic       done_res_o,
  input wire logic       success_o,
  input wire logic       last_o
);

  // stalled item stays up with its bus command unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bus_command_o))
    else $error("stalled result item changed");

  // completion always rides on a stop and closes the event's items
  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |->
      bus_command_o == i2cmrts_pkg::CmdStop && last_o)
    else $error("done without stop or not last");

  a_success_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && success_o |-> done_res_o)
    else $error("success without done");

  // received data comes with the next receive or the closing stop
  a_rx_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |->
      (bus_command_o == i2cmrts_pkg::CmdRecv) ||
      (bus_command_o == i2cmrts_pkg::CmdStop))
    else $error("read data on unexpected command");

endmodule

bind i2c_master_register_transfer_sequencer i2cmrts_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .bus_command_o (bus_command_o),
  .read_valid_o  (read_valid_o),
  .done_res_o    (done_res_o),
  .success_o     (success_o),
  .last_o        (last_o)
);
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the I2C register transfer sequencer
// Feeds requests, write data, ack responses and received bytes through the
// event channel. It predicts the bus command items for every event and checks
// each item taken from the result channel, field by field and in order.
// ----------------------------------------------------------------------------
module tb;
  import i2cmrts_pkg::*;

  localparam int CountMax    = (1 << CountBits) - 1;
  localparam int RandomItems = 396;
  localparam int Latency     = 10;   // stray-item wait before the verdict, with margin
  localparam int HoldCycles  = 80;   // one long receiver hold-off

  // how a directed row is checked: by the predictor, or by a typed answer
  typedef enum logic [1:0] {
    TypModel = 2'd0,  // predictor supplies the items
    TypNone  = 2'd1,  // event ignored, no items
    TypAbort = 2'd2,  // NACK: single stop, done, success low
    TypDone  = 2'd3   // clean finish: single stop, done, success high
  } typed_e;

  typedef struct packed {
    kind_e      kind;
    op_e        op;
    logic [7:0] addr;
    logic [7:0] regi;
    logic [7:0] cnt;
    logic [7:0] data;
    logic       nack;
  } ev_t;

  typedef struct packed {
    ev_t    ev;
    typed_e typed;
  } script_row_t;

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       ev_valid = 1'b0;
  logic       ev_stall;
  logic [1:0] ev_kind  = '0;
  logic [1:0] ev_op    = '0;
  logic [7:0] ev_addr  = '0;
  logic [7:0] ev_reg   = '0;
  logic [7:0] ev_cnt   = '0;
  logic [7:0] ev_data  = '0;
  logic       ev_nack  = 1'b0;

  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [2:0] bus_command;
  logic [7:0] send_byte;
  logic       send_nack_after;
  logic [7:0] read_data;
  logic       read_valid;
  logic       done_res;
  logic       success;
  logic       need_data;
  logic       last_item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_register_transfer_sequencer dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (ev_valid),
    .in_stall_o        (ev_stall),
    .kind_i            (ev_kind),
    .operation_i       (ev_op),
    .device_address_i  (ev_addr),
    .register_index_i  (ev_reg),
    .byte_count_i      (ev_cnt),
    .data_byte_i       (ev_data),
    .nack_i            (ev_nack),
    .out_valid_o       (res_valid),
    .out_stall_i       (res_stall),
    .bus_command_o     (bus_command),
    .send_byte_o       (send_byte),
    .send_nack_after_o (send_nack_after),
    .read_data_o       (read_data),
    .read_valid_o      (read_valid),
    .done_res_o        (done_res),
    .success_o         (success),
    .need_data_o       (need_data),
    .last_o            (last_item)
  );

  // --------------------------------------------------------------------------
  // sequencer predictor: own copy of the transaction state
  // --------------------------------------------------------------------------
  phase_e     seq_phase = PhIdle;
  op_e        seq_op    = OpProbe;
  logic [7:0] seq_addr  = '0;
  logic [7:0] seq_reg   = '0;
  count_t     seq_left  = '0;

  res_t bus_items[$];   // items caused by the event being offered
  res_t items_due[$];   // items still owed by the DUT, oldest first

  int   mismatch_count = 0;
  bit   hold_off_req   = 1'b0;  // sender asks the receiver for a long hold
  bit   eager          = 1'b0;  // sender stretch with no gaps

  function automatic res_t item(cmd_e c, logic [7:0] sb, logic nk, logic [7:0] rd,
                                logic rv, logic dn, logic ok, logic nd);
    res_t r;
    r = '0;
    r.cmd        = c;
    r.send_byte  = sb;
    r.send_nack  = nk;
    r.read_data  = rd;
    r.read_valid = rv;
    r.done       = dn;
    r.success    = ok;
    r.need_data  = nd;
    return r;
  endfunction

  // stop with done; transaction over
  function automatic void close_out(logic ok);
    bus_items.push_back(item(CmdStop, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, ok, 1'b0));
    seq_phase = PhIdle;
  endfunction

  // write path after an ack: ask for another byte or finish
  function automatic void request_next_byte();
    if (seq_left == 0) begin
      close_out(1'b1);
    end else begin
      bus_items.push_back(item(CmdNone, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
      seq_phase = PhWdata;
    end
  endfunction

  function automatic void plan_bus_items(ev_t e);
    int n;
    bus_items.delete();
    case (e.kind)
      KindReq: begin
        if (seq_phase == PhIdle && e.op != OpRsvd) begin
          n = int'(e.cnt);
          if (n > CountMax) n = CountMax;
          if (e.op == OpRead && n == 0) n = 1;   // zero-length read reads one byte
          seq_op   = e.op;
          seq_addr = e.addr;
          seq_reg  = e.regi;
          seq_left = count_t'(n);
          bus_items.push_back(item(CmdStart, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
          bus_items.push_back(item(CmdSend, e.addr, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
          seq_phase = PhAddrAck;
        end
      end
      KindData: begin
        if (seq_phase == PhWdata) begin
          bus_items.push_back(item(CmdSend, e.data, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
          seq_left  = seq_left - 1'b1;
          seq_phase = PhWdataAck;
        end
      end
      KindAck: begin
        if (seq_phase == PhAddrAck || seq_phase == PhRegAck ||
            seq_phase == PhWdataAck || seq_phase == PhRaddrAck) begin
          if (e.nack) begin
            close_out(1'b0);
          end else if (seq_phase == PhAddrAck) begin
            if (seq_op == OpProbe) begin
              close_out(1'b1);
            end else begin
              bus_items.push_back(item(CmdSend, seq_reg, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
                                       1'b0));
              seq_phase = PhRegAck;
            end
          end else if (seq_phase == PhRegAck) begin
            if (seq_op == OpWrite) begin
              request_next_byte();
            end else begin
              // stop and new start for the read phase, address with R/W set
              bus_items.push_back(item(CmdStop, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
              bus_items.push_back(item(CmdStart, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
                                       1'b0));
              bus_items.push_back(item(CmdSend, seq_addr | ReadBit, 1'b0, 8'h00, 1'b0, 1'b0,
                                       1'b0, 1'b0));
              seq_phase = PhRaddrAck;
            end
          end else if (seq_phase == PhWdataAck) begin
            request_next_byte();
          end else begin
            bus_items.push_back(item(CmdRecv, 8'h00, seq_left <= 1, 8'h00, 1'b0, 1'b0, 1'b0,
                                     1'b0));
            seq_phase = PhRx;
          end
        end
      end
      default: begin
        if (seq_phase == PhRx) begin
          seq_left = (seq_left == 0) ? seq_left : seq_left - 1'b1;
          if (seq_left == 0) begin
            bus_items.push_back(item(CmdStop, 8'h00, 1'b0, e.data, 1'b1, 1'b1, 1'b1, 1'b0));
            seq_phase = PhIdle;
          end else begin
            bus_items.push_back(item(CmdRecv, 8'h00, seq_left == 1, e.data, 1'b1, 1'b0,
                                     1'b0, 1'b0));
          end
        end
      end
    endcase
    if (bus_items.size() != 0) bus_items[bus_items.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic script_row_t row(kind_e k, op_e o, logic [7:0] a, logic [7:0] r,
                                      logic [7:0] c, logic [7:0] d, logic n, typed_e t);
    script_row_t s;
    s.ev.kind  = k;
    s.ev.op    = o;
    s.ev.addr  = a;
    s.ev.regi  = r;
    s.ev.cnt   = c;
    s.ev.data  = d;
    s.ev.nack  = n;
    s.typed    = t;
    return s;
  endfunction

  // Random event steered by the predicted phase: mostly the event the
  // sequencer waits for (with random content), sometimes pure noise.
  function automatic ev_t pick_event();
    ev_t e;
    int  roll;
    e.kind = kind_e'($urandom_range(0, 3));
    e.op   = op_e'($urandom_range(0, 3));
    e.addr = 8'($urandom);
    e.regi = 8'($urandom);
    e.cnt  = 8'($urandom);
    e.data = 8'($urandom);
    e.nack = 1'($urandom_range(0, 1));
    roll   = $urandom_range(0, 99);
    if (roll < 12) return e;
    case (seq_phase)
      PhIdle: begin
        e.kind = KindReq;
        e.op   = (roll < 16) ? OpRsvd : op_e'($urandom_range(0, 2));
        // short transfers mostly; an occasional long read
        if (e.op == OpRead && $urandom_range(0, 59) == 0) e.cnt = 8'($urandom_range(128, 255));
        else e.cnt = 8'($urandom_range(0, 4));
      end
      PhWdata: e.kind = KindData;
      PhRx:    e.kind = KindRx;
      default: begin
        e.kind = KindAck;
        e.nack = ($urandom_range(0, 11) == 0);
      end
    endcase
    return e;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Predict, drive, and hold until the transfer is taken. Called just after
  // a rising edge; returns just after the accepting edge.
  task automatic offer(ev_t e, typed_e t);
    plan_bus_items(e);
    if (t != TypModel) begin
      // typed answer replaces the predicted one; predictor state still advances
      bus_items.delete();
      if (t != TypNone) begin
        bus_items.push_back(item(CmdStop, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, t == TypDone,
                                 1'b0));
        bus_items[0].last = 1'b1;
      end
    end
    foreach (bus_items[k]) items_due.push_back(bus_items[k]);
    ev_valid <= 1'b1;
    ev_kind  <= e.kind;
    ev_op    <= e.op;
    ev_addr  <= e.addr;
    ev_reg   <= e.regi;
    ev_cnt   <= e.cnt;
    ev_data  <= e.data;
    ev_nack  <= e.nack;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      ev_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait, sender quiet, until every predicted item is back or the wait gives up
  task automatic wait_drained();
    int waited;
    waited = 0;
    ev_valid <= 1'b0;
    @(posedge clk);
    while (items_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // result side: take items, compare, choose next stall
  // --------------------------------------------------------------------------
  initial begin
    res_t want;
    int   stall_run;
    int   cyc;
    int   r;
    bit   calm;
    stall_run = 0;
    cyc       = 0;
    calm      = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (res_valid && !res_stall) begin
        if (items_due.size() == 0) begin
          $error("bus_command: expected no item, got %0d", bus_command);
          mismatch_count++;
        end else begin
          want = items_due.pop_front();
          check_field("bus_command", want.cmd, bus_command);
          check_field("send_byte", want.send_byte, send_byte);
          check_field("send_nack_after", want.send_nack, send_nack_after);
          check_field("read_data", want.read_data, read_data);
          check_field("read_valid", want.read_valid, read_valid);
          check_field("done_res", want.done, done_res);
          check_field("success", want.success, success);
          check_field("need_data", want.need_data, need_data);
          check_field("last", want.last, last_item);
        end
      end
      // stall pattern: calm stretches, single-cycle stalls, a few long runs
      if (hold_off_req) begin
        stall_run    = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (cyc % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (stall_run > 0) begin
        stall_run--;
        res_stall <= 1'b1;
      end else if (calm) begin
        res_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) stall_run = $urandom_range(8, 30);
        res_stall <= (r < 30);
      end
    end
  end

  // --------------------------------------------------------------------------
  // event side: directed script, then random traffic, then drain
  // --------------------------------------------------------------------------
  initial begin
    script_row_t script[$];
    int          n;

    // events that mean nothing out of a transaction, reserved op
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypNone));
    script.push_back(row(KindRx,   OpProbe, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, TypNone));
    script.push_back(row(KindData, OpWrite, 8'h00, 8'h00, 8'h00, 8'hA5, 1'b0, TypNone));
    script.push_back(row(KindReq,  OpRsvd,  8'h42, 8'h10, 8'h03, 8'h00, 1'b0, TypNone));
    // probe at address 0, request while busy, NACK on address
    script.push_back(row(KindReq,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindReq,  OpRead,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, TypNone));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, TypAbort));
    // probe at 0xFF, acked
    script.push_back(row(KindReq,  OpProbe, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypDone));
    // two-byte register write with extreme data
    script.push_back(row(KindReq,  OpWrite, 8'hA0, 8'hFF, 8'h02, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindData, OpProbe, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindData, OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypDone));
    // read with count zero: one byte, NACK on it
    script.push_back(row(KindReq,  OpRead,  8'hFE, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindRx,   OpProbe, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, TypModel));
    // zero-length write ends right after the index
    script.push_back(row(KindReq,  OpWrite, 8'h5A, 8'h80, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypModel));
    script.push_back(row(KindAck,  OpProbe, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TypDone));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[s]) begin
      offer(script[s].ev, script[s].typed);
      idle_gap(sender_gap());
    end

    // random traffic
    n = 0;
    while (n < RandomItems) begin
      if (n % 40 == 0) eager = ($urandom_range(0, 3) == 0);
      // long receiver hold while we keep pushing: queue fills, input stalls
      if (n == 120) begin
        eager        = 1'b1;
        hold_off_req = 1'b1;
      end
      if (n == 260) wait_drained();
      offer(pick_event(), TypModel);
      n++;
      idle_gap(sender_gap());
    end

    wait_drained();
    if (items_due.size() != 0) begin
      $error("bus_command: expected %0d more items, got none", items_due.size());
      mismatch_count++;
    end
    // let any stray item surface before the verdict
    repeat (Latency) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
